>>> rtl/core/apdf_pkg.sv
// ----------------------------------------------------------------------------
// apdf_pkg
// shared types and constants for the allpass delay filter
// ----------------------------------------------------------------------------
`default_nettype none

package apdf_pkg;

    localparam int GAIN_W    = 16;
    localparam int FRAC_BITS = 15;

    typedef logic signed [GAIN_W-1:0] gain_t;

    localparam gain_t GAIN_RESET = gain_t'(16384);

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_GAIN  = 1'b0,
        REG_DELAY = 1'b1
    } reg_idx_t;

endpackage

`default_nettype wire

>>> rtl/core/apdf_ram.sv
// ----------------------------------------------------------------------------
// apdf_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module apdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read during write to the same address returns the old word
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/apdf_mac.sv
// ----------------------------------------------------------------------------
// apdf_mac
// allpass sum g*(yd - x) + xd, truncated toward zero and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module apdf_mac #(
    parameter int SAMPLE_BITS = 8
) (
    input  wire apdf_pkg::gain_t               gain,
    input  wire logic signed [SAMPLE_BITS-1:0] x,
    input  wire logic signed [SAMPLE_BITS-1:0] xd,
    input  wire logic signed [SAMPLE_BITS-1:0] yd,
    output logic signed      [SAMPLE_BITS-1:0] y,
    output logic                               sat
);

    import apdf_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = GAIN_W + DIFF_W;
    localparam int ACC_W  = SAMPLE_BITS + 18;
    localparam int Q_W    = ACC_W - FRAC_BITS;

    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(2 ** (SAMPLE_BITS - 1)));

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;
    logic signed [Q_W-1:0]    q_floor;
    logic signed [Q_W-1:0]    q;

    always_comb
    begin
        diff    = DIFF_W'(yd) - DIFF_W'(x);
        prod    = PROD_W'(gain) * PROD_W'(diff);
        acc     = ACC_W'(prod) + (ACC_W'(xd) <<< FRAC_BITS);
        q_floor = Q_W'(acc >>> FRAC_BITS);
        // round toward zero for negative sums with a fraction
        if (acc[ACC_W-1] && (|acc[FRAC_BITS-1:0]))
        begin
            q = q_floor + Q_W'(1);
        end
        else
        begin
            q = q_floor;
        end

        if (q > Q_MAX)
        begin
            y   = SAMPLE_BITS'(Q_MAX);
            sat = 1'b1;
        end
        else if (q < Q_MIN)
        begin
            y   = SAMPLE_BITS'(Q_MIN);
            sat = 1'b1;
        end
        else
        begin
            y   = SAMPLE_BITS'(q);
            sat = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/allpass_delay_filter.sv
// ----------------------------------------------------------------------------
// allpass_delay_filter
// schroeder allpass: y = -g*x[n] + x[n-D] + g*y[n-D], saturated output
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries one sample word (sample_in,
//   last_sample); output channel out_valid/out_ready returns one word each
//   (sample_out, saturated, last_out) in the same order
//   one word per cycle is sustained while out_ready is high, set by the
//   single read and write port of the history ram whose read for a word
//   is issued when that word is accepted; the gain and delay registers
//   sit on the apb port (gain at 0x0, delay at 0x4); the user must write
//   them only while the filter holds no word, not enforced by the block
//   reset clears the write pointer, fill count and both valid flags; gain
//   goes to 0.5 and delay to 1; history ram is not cleared, the fill count
//   keeps reads away from entries not yet written
//   when out_ready is low the result holds, one more word may be taken
//   into the input stage, then in_ready drops until the output drains
//   last_sample ends a sound and restarts the history for the next one
// ----------------------------------------------------------------------------
`default_nettype none

module allpass_delay_filter #(
    parameter int SAMPLE_BITS = 8,
    parameter int MAX_DELAY   = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire logic                          last_sample,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed      [SAMPLE_BITS-1:0] sample_out,
    output logic                               saturated,
    output logic                               last_out
);

    import apdf_pkg::*;

    localparam int AW = $clog2(MAX_DELAY);
    localparam int DW = $clog2(MAX_DELAY + 1);

    localparam logic [DW:0]   MAX_EXT  = (DW + 1)'(MAX_DELAY);
    localparam logic [DW-1:0] MAX_D    = DW'(MAX_DELAY);
    localparam logic [AW-1:0] WP_LAST  = AW'(MAX_DELAY - 1);

    // configuration
    gain_t           gain_reg;
    logic [DW-1:0]   delay_reg;
    reg_idx_t        reg_idx;
    logic            cfg_write;

    // pointers
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   wp_next;
    logic [DW-1:0]   fill_reg;
    logic [DW-1:0]   fill_next;
    logic [DW-1:0]   d_eff;
    logic [DW:0]     rd_full;
    logic [AW-1:0]   rd_addr;
    logic            hist_ok;

    // input stage
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic                          s1_last_reg;
    logic [AW-1:0]                 s1_wp_reg;
    logic                          s1_hist_reg;
    logic                          s1_byp_reg;

    // bypass of the word written in the accept cycle
    logic signed [SAMPLE_BITS-1:0] byp_x_reg;
    logic signed [SAMPLE_BITS-1:0] byp_y_reg;

    // output stage
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_y_reg;
    logic                          out_sat_reg;
    logic                          out_last_reg;

    logic                          in_accept;
    logic                          out_advance;
    logic [2*SAMPLE_BITS-1:0]      ram_rdata;
    logic [2*SAMPLE_BITS-1:0]      ram_wdata;
    logic signed [SAMPLE_BITS-1:0] xd;
    logic signed [SAMPLE_BITS-1:0] yd;
    logic signed [SAMPLE_BITS-1:0] mac_y;
    logic                          mac_sat;

    // apb
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            REG_GAIN:  prdata = 32'($unsigned(gain_reg));
            REG_DELAY: prdata = 32'(delay_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            delay_reg <= DW'(1);
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_GAIN:  gain_reg  <= gain_t'(pwdata[GAIN_W-1:0]);
                REG_DELAY: delay_reg <= pwdata[DW-1:0];
                default:   gain_reg  <= gain_reg;
            endcase
        end
    end

    // handshake
    assign out_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready    = !s1_valid_reg || out_advance;
    assign in_accept   = in_valid && in_ready;

    // delay clamp, read address, next write pointer and fill count
    always_comb
    begin
        if (delay_reg == '0)
        begin
            d_eff = DW'(1);
        end
        else if (delay_reg > MAX_D)
        begin
            d_eff = MAX_D;
        end
        else
        begin
            d_eff = delay_reg;
        end

        hist_ok = (fill_reg >= d_eff);

        if ((DW + 1)'(wp_reg) >= (DW + 1)'(d_eff))
        begin
            rd_full = (DW + 1)'(wp_reg) - (DW + 1)'(d_eff);
        end
        else
        begin
            rd_full = (DW + 1)'(wp_reg) + MAX_EXT - (DW + 1)'(d_eff);
        end
        rd_addr = rd_full[AW-1:0];

        wp_next = (wp_reg == WP_LAST) ? '0 : wp_reg + AW'(1);

        if (last_sample)
        begin
            fill_next = '0;
        end
        else if (fill_reg < MAX_D)
        begin
            fill_next = fill_reg + DW'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg    <= sample_in;
            s1_last_reg <= last_sample;
            s1_wp_reg   <= wp_reg;
            s1_hist_reg <= hist_ok;
            s1_byp_reg  <= (d_eff == DW'(1)) && s1_valid_reg;
        end

        if (out_advance)
        begin
            byp_x_reg    <= s1_x_reg;
            byp_y_reg    <= mac_y;
            out_y_reg    <= mac_y;
            out_sat_reg  <= mac_sat;
            out_last_reg <= s1_last_reg;
        end
    end

    // history select
    always_comb
    begin
        if (!s1_hist_reg)
        begin
            xd = '0;
            yd = '0;
        end
        else if (s1_byp_reg)
        begin
            xd = byp_x_reg;
            yd = byp_y_reg;
        end
        else
        begin
            xd = $signed(ram_rdata[SAMPLE_BITS-1:0]);
            yd = $signed(ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
    end

    assign ram_wdata = {mac_y, s1_x_reg};

    apdf_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_DELAY)
    ) u_hist_ram (
        .clk   (clk),
        .we    (out_advance),
        .waddr (s1_wp_reg),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    apdf_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .gain (gain_reg),
        .x    (s1_x_reg),
        .xd   (xd),
        .yd   (yd),
        .y    (mac_y),
        .sat  (mac_sat)
    );

    assign out_valid  = out_valid_reg;
    assign sample_out = out_y_reg;
    assign saturated  = out_sat_reg;
    assign last_out   = out_last_reg;

endmodule

`default_nettype wire
